// File: design/ius2x_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the 2x first-order-hold upscaler.
// No dependencies.
package ius2x_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_TAG_W  = 12;
   localparam int COL_TAG_W  = 9;
   localparam int CSR_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int SRC_WIDTH_W  = 10;
   localparam int SRC_HEIGHT_W = 13;
   localparam int SLOTS      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;

   localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = 10'd512;
   localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RST = 13'd512;

   typedef struct packed {
      logic [ROW_TAG_W-1:0] row;
      logic [COL_TAG_W-1:0] col;
      logic [PIX_W-1:0]     tl;
      logic [PIX_W-1:0]     tr;
      logic [PIX_W-1:0]     bl;
      logic                 last;
   } quad_type;

   typedef struct packed {
      logic     valid;
      quad_type quad;
   } entry_type;

   // rounded-up mean (a+b+1)>>1
   function automatic logic [PIX_W-1:0] mean_up(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      logic [PIX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
      return sum[PIX_W:1];
   endfunction

endpackage

// File: design/image_upscale_2x_first_order.sv
`timescale 1ns / 1ps
// Top level of the 2x first-order-hold upscaler: counters, line RAM, quad build, cell chain.
// Depends on ius2x_pkg, ius2x_ram, ius2x_cell.
//
// Use:
//  - req channel: one 8-bit gray source pixel per beat, raster order.
//  - rsp channel: one 2x2 output quad per beat, tagged with its source row and
//    column; last_of_run marks the final quad caused by one source pixel.
//  - csr port: index 0 src_width, index 1 src_height. Any write restarts the
//    frame at row 0, column 0. Write only while the block is idle.
// The first quad of a pixel passes the registered quad stage and then the first chain cell
// before it appears on rsp. Pixels of row 0 give no quad unless the image has one row.
// Throughput: one pixel per cycle while rsp_stall is low and each pixel gives at most
// one quad. A pixel giving n quads (row ends, last row) holds req back: the
// four-cell output chain hands out one quad per cycle while rsp_stall is low and takes the
// next pixel's quads only once its last quad is leaving.
// Reset clears the counters, the left and above-left pixels and the chain;
// the line RAM is not cleared, and what row 0 reads from it is never used.
// While rsp_stall is high the chain holds; req_stall rises while the quad
// stage holds a pixel whose quads the chain cannot take.
module image_upscale_2x_first_order
   import ius2x_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PIX_W-1:0]        req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ROW_TAG_W-1:0]    rsp_src_row,
   output logic [COL_TAG_W-1:0]    rsp_src_col,
   output logic [PIX_W-1:0]        rsp_pix_top_left,
   output logic [PIX_W-1:0]        rsp_pix_top_right,
   output logic [PIX_W-1:0]        rsp_pix_bottom_left,
   output logic [PIX_W-1:0]        rsp_pix_bottom_right,
   output logic                    rsp_last_of_run,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WCMP = (CW + 1 > SRC_WIDTH_W)  ? CW + 1 : SRC_WIDTH_W;
   localparam int HCMP = (RW + 1 > SRC_HEIGHT_W) ? RW + 1 : SRC_HEIGHT_W;

   logic [SRC_WIDTH_W-1:0]  width_ff;
   logic [SRC_HEIGHT_W-1:0] height_ff;
   logic [WCMP-1:0]         w_ext, w_eff;
   logic [HCMP-1:0]         h_ext, h_eff;
   logic [CW-1:0]           last_col;
   logic [RW-1:0]           last_row;

   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [PIX_W-1:0] left_ff, left_in;
   logic [PIX_W-1:0] al_ff;

   logic             b_valid_ff, b_valid_in;
   logic [PIX_W-1:0] b_pix_ff, b_left_ff;
   logic [CW-1:0]    b_col_ff;
   logic [RW-1:0]    b_row_ff;
   logic             b_row_nz_ff, b_col_nz_ff, b_col_last_ff, b_row_last_ff;

   logic             req_accept;
   logic             b_fire;
   logic [PIX_W-1:0] above;
   logic [SLOTS-1:0] vs;
   quad_type         slots [SLOTS];
   entry_type        bundle [SLOTS];
   entry_type        neighbor [SLOTS];
   entry_type        cell_q [SLOTS];
   logic [1:0]       pos;
   logic [ROW_TAG_W-1:0] row_up_tag, row_tag;
   logic [COL_TAG_W-1:0] col_lf_tag, col_tag;
   logic             pop, room, chain_load, any_quad;

   // effective geometry
   always_comb begin
      w_ext = WCMP'(width_ff);
      h_ext = HCMP'(height_ff);
      priority if (w_ext == '0) begin
         w_eff = WCMP'(1);
      end else if (w_ext > WCMP'(MAX_WIDTH)) begin
         w_eff = WCMP'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      priority if (h_ext == '0) begin
         h_eff = HCMP'(1);
      end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
         h_eff = HCMP'(MAX_HEIGHT);
      end else begin
         h_eff = h_ext;
      end
      last_col = CW'(w_eff - WCMP'(1));
      last_row = RW'(h_eff - HCMP'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SRC_WIDTH_RST;
         height_ff <= SRC_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  width_ff  <= csr_wdata[SRC_WIDTH_W-1:0];
            CSR_SRC_HEIGHT: height_ff <= csr_wdata[SRC_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // input side
   assign req_stall  = b_valid_ff & ~b_fire;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (req_accept) begin
         left_in = req_pixel;
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (req_accept) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         left_ff    <= '0;
         al_ff      <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         left_ff    <= left_in;
         b_valid_ff <= b_valid_in;
         if (b_fire) begin
            al_ff <= above;
         end
      end
      if (req_accept) begin
         b_pix_ff      <= req_pixel;
         b_left_ff     <= left_ff;
         b_col_ff      <= col_ff;
         b_row_ff      <= row_ff;
         b_row_nz_ff   <= (row_ff != '0);
         b_col_nz_ff   <= (col_ff != '0);
         b_col_last_ff <= (col_ff == last_col);
         b_row_last_ff <= (row_ff == last_row);
      end
   end

   // read-before-write line store
   ius2x_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (req_accept),
      .wr_addr(col_ff),
      .wr_data(req_pixel),
      .rd_en  (req_accept),
      .rd_addr(col_ff),
      .rd_data(above)
   );

   // quad build and compaction
   always_comb begin
      row_up_tag = ROW_TAG_W'(b_row_ff - RW'(1));
      row_tag    = ROW_TAG_W'(b_row_ff);
      col_lf_tag = COL_TAG_W'(b_col_ff - CW'(1));
      col_tag    = COL_TAG_W'(b_col_ff);

      slots[0].row  = row_up_tag;
      slots[0].col  = col_lf_tag;
      slots[0].tl   = al_ff;
      slots[0].tr   = mean_up(al_ff, above);
      slots[0].bl   = mean_up(al_ff, b_left_ff);
      slots[0].last = 1'b0;

      slots[1].row  = row_up_tag;
      slots[1].col  = col_tag;
      slots[1].tl   = above;
      slots[1].tr   = above;
      slots[1].bl   = mean_up(above, b_pix_ff);
      slots[1].last = 1'b0;

      slots[2].row  = row_tag;
      slots[2].col  = col_lf_tag;
      slots[2].tl   = b_left_ff;
      slots[2].tr   = mean_up(b_left_ff, b_pix_ff);
      slots[2].bl   = b_left_ff;
      slots[2].last = 1'b0;

      slots[3].row  = row_tag;
      slots[3].col  = col_tag;
      slots[3].tl   = b_pix_ff;
      slots[3].tr   = b_pix_ff;
      slots[3].bl   = b_pix_ff;
      slots[3].last = 1'b0;

      vs[0] = b_row_nz_ff & b_col_nz_ff;
      vs[1] = b_row_nz_ff & b_col_last_ff;
      vs[2] = b_row_last_ff & b_col_nz_ff;
      vs[3] = b_row_last_ff & b_col_last_ff;

      pos = '0;
      for (int i = 0; i < SLOTS; i++) begin
         bundle[i] = '0;
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (vs[k]) begin
            bundle[pos].valid     = 1'b1;
            bundle[pos].quad      = slots[k];
            bundle[pos].quad.last = ~|(vs >> (k + 1));
            pos = pos + 2'd1;
         end
      end
   end

   // output chain
   assign any_quad   = |vs;
   assign pop        = cell_q[0].valid & ~rsp_stall;
   assign room       = ~cell_q[1].valid & ~cell_q[2].valid & ~cell_q[3].valid &
                       (~cell_q[0].valid | pop);
   assign chain_load = b_valid_ff & any_quad & room;
   assign b_fire     = b_valid_ff & (~any_quad | room);

   for (genvar i = 0; i < SLOTS; i++) begin : g_chain
      if (i == SLOTS - 1) begin : g_tail
         assign neighbor[i] = '0;
      end else begin : g_link
         assign neighbor[i] = cell_q[i+1];
      end
      ius2x_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (chain_load),
         .shift     (pop),
         .load_entry(bundle[i]),
         .next_entry(neighbor[i]),
         .entry     (cell_q[i])
      );
   end

   assign rsp_valid            = cell_q[0].valid;
   assign rsp_src_row          = cell_q[0].quad.row;
   assign rsp_src_col          = cell_q[0].quad.col;
   assign rsp_pix_top_left     = cell_q[0].quad.tl;
   assign rsp_pix_top_right    = cell_q[0].quad.tr;
   assign rsp_pix_bottom_left  = cell_q[0].quad.bl;
   assign rsp_pix_bottom_right = cell_q[0].quad.tl;
   assign rsp_last_of_run      = cell_q[0].quad.last;

endmodule

// File: design/ius2x_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module ius2x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ius2x_cell.sv
`timescale 1ns / 1ps
// One cell of the output chain: holds a quad, loads in parallel or takes its neighbor's.
// Depends on ius2x_pkg.
module ius2x_cell
   import ius2x_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  logic      shift,
   input  entry_type load_entry,
   input  entry_type next_entry,
   output entry_type entry
);

   logic     valid_ff, valid_in;
   quad_type quad_ff, quad_in;

   always_comb begin
      priority if (load) begin
         valid_in = load_entry.valid;
         quad_in  = load_entry.quad;
      end else if (shift) begin
         valid_in = next_entry.valid;
         quad_in  = next_entry.quad;
      end else begin
         valid_in = valid_ff;
         quad_in  = quad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      quad_ff <= quad_in;
   end

   assign entry.valid = valid_ff;
   assign entry.quad  = quad_ff;

endmodule

// File: design/ius2x_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the upscaler, bound to the top level.
// Depends on ius2x_pkg and image_upscale_2x_first_order.
module ius2x_checker
   import ius2x_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [ROW_TAG_W-1:0] rsp_src_row,
   input logic [COL_TAG_W-1:0] rsp_src_col,
   input logic [PIX_W-1:0]     rsp_pix_top_left,
   input logic [PIX_W-1:0]     rsp_pix_top_right,
   input logic [PIX_W-1:0]     rsp_pix_bottom_left,
   input logic [PIX_W-1:0]     rsp_pix_bottom_right,
   input logic                 rsp_last_of_run
);

   // no beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_src_row) &&
         $stable(rsp_src_col) && $stable(rsp_pix_top_left) &&
         $stable(rsp_pix_top_right) && $stable(rsp_pix_bottom_left) &&
         $stable(rsp_last_of_run))
      else $error("stalled rsp beat changed");

   // the quads of one pixel leave without gaps
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a run of quads");

   // input only backs up behind a waiting quad
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending quad");

   a_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pix_bottom_right == rsp_pix_top_left)
      else $error("bottom-right differs from top-left");

endmodule

bind image_upscale_2x_first_order ius2x_checker u_ius2x_checker (.*);
